// File: rtl/rglf_pkg.sv
package rglf_pkg;

    // Line store geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Configuration register widths
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;

    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    // Pixel and luma arithmetic
    localparam int CHAN_W     = 8;
    localparam int GRAY_W     = 8;
    localparam int SUM_W      = 18;
    localparam int LUMA_R     = 299;
    localparam int LUMA_G     = 587;
    localparam int LUMA_B     = 114;
    localparam int LUMA_DIV   = 1000;
    // floor(2^24 / 1000): the estimate is at most one below the true quotient
    localparam int LUMA_SHIFT = 24;
    localparam int LUMA_RECIP = 16777;
    localparam int PROD_W     = SUM_W + 15;

    // Register indexes on the configuration port
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [GRAY_W-1:0] filtered;
        logic              frame_end;
    } result_t;

    // Position of the pixel about to be accepted
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] next_col;
        logic             has_result;
        logic             interior;
        logic             frame_end;
    } scan_info_t;

endpackage

// File: rtl/rgb_gray_laplacian_filter.sv
// RGB pixels in, Laplacian-filtered gray pixels out, raster order.
//
// pixel channel: one RGB request per pixel, valid/ready. Each pixel of row
// y >= 1 produces one result for row y-1 at the same column; row 0 gives no
// result and the all-zero last row is never sent. frame_end marks the last
// result of a frame. cfg_write/cfg_index/cfg_data set image width and
// height; write them only while no request is in flight.
//
// Throughput is one pixel per clock unless the output stalls. A result
// passes stage one, stage two and the output register. Each pixel reads
// both line stores once (the next column, fetched ahead) and writes back
// once on leaving stage one: one access of each kind per store per pixel.
//
// When the receiver stalls, the result waits in the output register and
// one further result goes into a skid register; pixel_ready then drops
// until the output is taken. Reset clears the counters and the pipeline
// and restores width 640 and height 480; the line stores are not cleared,
// and the first frame's leading rows fill them before they are used.
module rgb_gray_laplacian_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  rglf_pkg::pixel_t                pixel,
    output logic                            result_valid,
    input  logic                            result_ready,
    output rglf_pkg::result_t               result,
    input  logic                            cfg_write,
    input  rglf_pkg::cfg_reg_t              cfg_index,
    input  logic [rglf_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int GW = rglf_pkg::GRAY_W;
    localparam int SW = rglf_pkg::SUM_W;
    localparam int LW = GW + 3;

    rglf_pkg::scan_info_t info;

    logic          advance;
    logic          accept;
    logic [SW-1:0] sum_next;

    // Line store ports
    logic [GW-1:0] above_rdata;
    logic [GW-1:0] two_rdata;
    logic [GW-1:0] gray;
    logic          store_we;

    // Stage one: luma sum and neighbours
    logic                       s1_valid_reg;
    logic [SW-1:0]              s1_sum_reg;
    logic [rglf_pkg::COL_W-1:0] s1_col_reg;
    logic                       s1_has_result_reg;
    logic                       s1_interior_reg;
    logic                       s1_frame_end_reg;
    logic [GW-1:0]              s1_up_reg;
    logic [GW-1:0]              s1_centre_reg;
    logic [GW-1:0]              s1_left_reg;
    logic [GW-1:0]              prev_centre_reg;

    // Stage two: gray and all four neighbours
    logic          s2_valid_reg;
    logic [GW-1:0] s2_gray_reg;
    logic [GW-1:0] s2_up_reg;
    logic [GW-1:0] s2_centre_reg;
    logic [GW-1:0] s2_left_reg;
    logic [GW-1:0] s2_right_reg;
    logic          s2_interior_reg;
    logic          s2_frame_end_reg;

    // Laplacian
    logic [GW+1:0]     neigh_sum;
    logic signed [LW-1:0] lap;
    rglf_pkg::result_t res_next;
    logic              push;

    // Output register and skid
    rglf_pkg::result_t out_data_reg;
    rglf_pkg::result_t skid_data_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    assign advance     = !skid_valid_reg;
    assign accept      = pixel_valid && advance;
    assign pixel_ready = advance;

    rglf_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .info      (info)
    );

    // Weighted luma sum of the incoming pixel
    assign sum_next = SW'(pixel.red)   * SW'(rglf_pkg::LUMA_R) +
                      SW'(pixel.green) * SW'(rglf_pkg::LUMA_G) +
                      SW'(pixel.blue)  * SW'(rglf_pkg::LUMA_B);

    rglf_luma u_luma (
        .sum  (s1_sum_reg),
        .gray (gray)
    );

    // Write back the column of stage one; fetch the next column ahead
    assign store_we = advance && s1_valid_reg;

    rglf_ram #(
        .WIDTH (GW),
        .DEPTH (rglf_pkg::MAX_WIDTH)
    ) u_line_above (
        .clk   (clk),
        .we    (store_we),
        .waddr (s1_col_reg),
        .wdata (gray),
        .re    (accept),
        .raddr (info.next_col),
        .rdata (above_rdata)
    );

    rglf_ram #(
        .WIDTH (GW),
        .DEPTH (rglf_pkg::MAX_WIDTH)
    ) u_line_two_above (
        .clk   (clk),
        .we    (store_we),
        .waddr (s1_col_reg),
        .wdata (s1_centre_reg),
        .re    (accept),
        .raddr (info.next_col),
        .rdata (two_rdata)
    );

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pixel_valid;
            s2_valid_reg <= s1_valid_reg && s1_has_result_reg;
        end
    end

    // Capture the request and the prefetched column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg        <= sum_next;
            s1_col_reg        <= info.col;
            s1_has_result_reg <= info.has_result;
            s1_interior_reg   <= info.interior;
            s1_frame_end_reg  <= info.frame_end;
            s1_up_reg         <= two_rdata;
            s1_centre_reg     <= above_rdata;
            s1_left_reg       <= prev_centre_reg;
            prev_centre_reg   <= above_rdata;
        end
    end

    // Advance to stage two; the right neighbour is the fetch just returned
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_gray_reg      <= gray;
            s2_up_reg        <= s1_up_reg;
            s2_centre_reg    <= s1_centre_reg;
            s2_left_reg      <= s1_left_reg;
            s2_right_reg     <= above_rdata;
            s2_interior_reg  <= s1_interior_reg;
            s2_frame_end_reg <= s1_frame_end_reg;
        end
    end

    // Four-neighbour Laplacian, clamped, zero on the border
    assign neigh_sum = (GW+2)'(s2_up_reg) + (GW+2)'(s2_gray_reg) +
                       (GW+2)'(s2_left_reg) + (GW+2)'(s2_right_reg);
    assign lap = $signed({1'b0, neigh_sum}) - $signed({1'b0, s2_centre_reg, 2'b00});

    always_comb
    begin
        res_next.frame_end = s2_frame_end_reg;
        if (!s2_interior_reg || lap < 0)
            res_next.filtered = '0;
        else if (lap > $signed(LW'(255)))
            res_next.filtered = '1;
        else
            res_next.filtered = lap[GW-1:0];
    end

    assign push = advance && s2_valid_reg;

    // Output and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !result_ready)
        begin
            if (push)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= push;
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !result_ready)
        begin
            if (push)
                skid_data_reg <= res_next;
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            out_data_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// File: rtl/rglf_ram.sv
module rglf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rglf_luma.sv
module rglf_luma (
    input  logic [rglf_pkg::SUM_W-1:0]  sum,
    output logic [rglf_pkg::GRAY_W-1:0] gray
);

    logic [rglf_pkg::PROD_W-1:0] prod;
    logic [rglf_pkg::GRAY_W-1:0] q_est;
    logic [rglf_pkg::SUM_W-1:0]  back;
    logic [rglf_pkg::SUM_W-1:0]  rem;

    // Estimate the quotient by reciprocal multiply
    assign prod  = rglf_pkg::PROD_W'(sum) * rglf_pkg::PROD_W'(rglf_pkg::LUMA_RECIP);
    assign q_est = prod[rglf_pkg::LUMA_SHIFT +: rglf_pkg::GRAY_W];

    // Correct an estimate that falls one short
    assign back = rglf_pkg::SUM_W'(q_est) * rglf_pkg::SUM_W'(rglf_pkg::LUMA_DIV);
    assign rem  = sum - back;
    assign gray = (rem >= rglf_pkg::SUM_W'(rglf_pkg::LUMA_DIV)) ?
                  q_est + rglf_pkg::GRAY_W'(1) : q_est;

endmodule

// File: rtl/rglf_scan.sv
module rglf_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            cfg_write,
    input  rglf_pkg::cfg_reg_t              cfg_index,
    input  logic [rglf_pkg::CFG_DATA_W-1:0] cfg_data,
    output rglf_pkg::scan_info_t            info
);

    logic [rglf_pkg::WIDTH_W-1:0]  width_reg;
    logic [rglf_pkg::HEIGHT_W-1:0] height_reg;
    logic [rglf_pkg::COL_W-1:0]    col_reg;
    logic [rglf_pkg::COL_W-1:0]    col_next;
    logic [rglf_pkg::ROW_W-1:0]    row_reg;
    logic [rglf_pkg::ROW_W-1:0]    row_next;
    logic [rglf_pkg::WIDTH_W-1:0]  width_eff;
    logic [rglf_pkg::HEIGHT_W-1:0] height_eff;
    logic                          row_end;
    logic                          last_row;
    logic                          row_inside;

    // Saturate the size registers
    always_comb
    begin
        if (width_reg < rglf_pkg::WIDTH_MIN)
            width_eff = rglf_pkg::WIDTH_MIN;
        else if (width_reg > rglf_pkg::WIDTH_MAX)
            width_eff = rglf_pkg::WIDTH_MAX;
        else
            width_eff = width_reg;

        if (height_reg < rglf_pkg::HEIGHT_MIN)
            height_eff = rglf_pkg::HEIGHT_MIN;
        else if (height_reg > rglf_pkg::HEIGHT_MAX)
            height_eff = rglf_pkg::HEIGHT_MAX;
        else
            height_eff = height_reg;
    end

    // Row and frame boundaries
    assign row_end    = rglf_pkg::WIDTH_W'(col_reg) >= (width_eff - rglf_pkg::WIDTH_W'(1));
    assign last_row   = rglf_pkg::HEIGHT_W'(row_reg) >= (height_eff - rglf_pkg::HEIGHT_W'(1));
    assign row_inside = rglf_pkg::HEIGHT_W'(row_reg) < height_eff;

    always_comb
    begin
        col_next = row_end ? '0 : col_reg + rglf_pkg::COL_W'(1);
        if (row_end)
            row_next = last_row ? '0 : row_reg + rglf_pkg::ROW_W'(1);
        else
            row_next = row_reg;
    end

    // Position info for the next request
    always_comb
    begin
        info.col        = col_reg;
        info.next_col   = col_next;
        info.has_result = (row_reg != '0);
        info.interior   = (row_reg >= rglf_pkg::ROW_W'(2)) && row_inside &&
                          (col_reg != '0) && !row_end;
        info.frame_end  = row_end && last_row;
    end

    // Hold the size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rglf_pkg::WIDTH_RESET;
            height_reg <= rglf_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rglf_pkg::REG_IMAGE_WIDTH:
                    width_reg <= cfg_data[rglf_pkg::WIDTH_W-1:0];
                rglf_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= cfg_data[rglf_pkg::HEIGHT_W-1:0];
                default:
                    width_reg <= width_reg;
            endcase
        end
    end

    // Advance the raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: rtl/rglf_checker.sv
module rglf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pixel_ready,
    input logic              result_valid,
    input logic              result_ready,
    input rglf_pkg::result_t result
);

    // Hold a stalled result
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    // Back-pressure only comes from a waiting result
    a_ready_low_waits: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> result_valid)
        else $error("pixel request refused with no result waiting");

    a_ready_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready && !result_ready |=> !pixel_ready)
        else $error("pixel ready rose while output still stalled");

    // Frame end falls on the right border
    a_frame_end_border: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_end |-> result.filtered == '0)
        else $error("frame end result not on border");

endmodule

bind rgb_gray_laplacian_filter rglf_checker u_rglf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
